// ===== hdl/afbu_pkg.sv =====
package afbu_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 13;
  localparam int unsigned KindW  = 2;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH_DEF     = 2;

  // result kinds
  localparam logic [KindW-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KindW-1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [KindW-1:0] KIND_DISCARD = 2'd2;

  // a frame needs more than this many stored bytes to be accepted
  localparam logic [CountW-1:0] MIN_ACCEPT_COUNT = 13'd2;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_FRAME_LIMIT = 2'd0;
  localparam logic [1:0] REG_END_BYTE    = 2'd1;
  localparam logic [1:0] REG_ESCAPE_BYTE = 2'd2;
  localparam logic [1:0] REG_ESCAPE_XOR  = 2'd3;

  localparam logic [CountW-1:0] FRAME_LIMIT_RST = 13'd512;
  localparam logic [ByteW-1:0]  END_BYTE_RST    = 8'h7E;
  localparam logic [ByteW-1:0]  ESCAPE_BYTE_RST = 8'h7D;
  localparam logic [ByteW-1:0]  ESCAPE_XOR_RST  = 8'h20;

  typedef struct packed {
    logic [CountW-1:0] frame_limit;
    logic [ByteW-1:0]  end_byte;
    logic [ByteW-1:0]  escape_byte;
    logic [ByteW-1:0]  escape_xor;
  } afbu_cfg_t;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ByteW-1:0]  data;
    logic [CountW-1:0] count;
  } afbu_entry_t;

endpackage

// ===== hdl/afbu_front.sv =====
module afbu_front #(
  parameter int unsigned MAX_FRAME_BYTES = afbu_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        q_full,
  input  logic [afbu_pkg::ByteW-1:0]  in_data_byte,
  input  logic                        in_line_error,
  input  afbu_pkg::afbu_cfg_t         cfg,
  output logic                        push,
  output afbu_pkg::afbu_entry_t       push_entry
);

  localparam int unsigned LimW = 17;
  localparam logic [LimW-1:0] MaxLim = LimW'(MAX_FRAME_BYTES);
  localparam logic [afbu_pkg::CountW-1:0] MaxLimC = afbu_pkg::CountW'(MAX_FRAME_BYTES);

  logic [afbu_pkg::CountW-1:0] byte_count_r, byte_count_nxt;
  logic                        escape_armed_r, escape_armed_nxt;
  logic                        frame_error_r, frame_error_nxt;

  logic                        accept;
  logic [afbu_pkg::CountW-1:0] limit;
  logic [afbu_pkg::ByteW-1:0]  esc_code_a, esc_code_b, decoded;
  logic                        is_end, is_escape, is_coded;

  assign accept     = in_valid && !q_full;
  assign esc_code_a = cfg.escape_byte ^ cfg.escape_xor;
  assign esc_code_b = cfg.end_byte ^ cfg.escape_xor;
  assign is_end     = (in_data_byte == cfg.end_byte);
  assign is_escape  = (in_data_byte == cfg.escape_byte);
  assign is_coded   = (in_data_byte == esc_code_a) || (in_data_byte == esc_code_b);

  always_comb begin
    if ({{(LimW - afbu_pkg::CountW){1'b0}}, cfg.frame_limit} > MaxLim) begin
      limit = MaxLimC;
    end else begin
      limit = cfg.frame_limit;
    end
  end

  always_comb begin
    byte_count_nxt   = byte_count_r;
    escape_armed_nxt = escape_armed_r;
    frame_error_nxt  = frame_error_r;
    decoded          = in_data_byte;
    push             = 1'b0;
    push_entry.kind  = afbu_pkg::KIND_PAYLOAD;
    push_entry.data  = in_data_byte;
    push_entry.count = byte_count_r;
    if (accept) begin
      priority if (in_line_error) begin
        frame_error_nxt = 1'b1;
      end else if (is_end) begin
        push = 1'b1;
        push_entry.kind = (!frame_error_r && byte_count_r > afbu_pkg::MIN_ACCEPT_COUNT) ?
                          afbu_pkg::KIND_ACCEPT : afbu_pkg::KIND_DISCARD;
        byte_count_nxt   = '0;
        escape_armed_nxt = 1'b0;
        frame_error_nxt  = 1'b0;
      end else if (is_escape) begin
        escape_armed_nxt = 1'b1;
      end else begin
        if (is_coded && escape_armed_r) begin
          escape_armed_nxt = 1'b0;
          decoded = in_data_byte ^ cfg.escape_xor;
        end
        push_entry.data = decoded;
        if (!frame_error_r) begin
          if (byte_count_r < limit) begin
            byte_count_nxt = byte_count_r + 13'd1;
            push = 1'b1;
          end else begin
            // overflow: drop and poison the frame
            frame_error_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r   <= '0;
      escape_armed_r <= 1'b0;
      frame_error_r  <= 1'b0;
    end else begin
      byte_count_r   <= byte_count_nxt;
      escape_armed_r <= escape_armed_nxt;
      frame_error_r  <= frame_error_nxt;
    end
  end

endmodule

// ===== hdl/afbu_queue.sv =====
module afbu_queue #(
  parameter int unsigned DEPTH = afbu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  afbu_pkg::afbu_entry_t push_entry,
  input  logic                  pop,
  output logic                  full,
  output logic                  not_empty,
  output afbu_pkg::afbu_entry_t head
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  afbu_pkg::afbu_entry_t slot_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full      = (count_r == FullCnt);
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hdl/afbu_back.sv =====
module afbu_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_not_empty,
  input  afbu_pkg::afbu_entry_t         q_head,
  output logic                          q_pop,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [afbu_pkg::KindW-1:0]    out_kind,
  output logic [afbu_pkg::ByteW-1:0]    out_payload_byte,
  output logic [afbu_pkg::CountW-1:0]   out_frame_length
);

  logic                        out_valid_r, out_valid_nxt;
  logic [afbu_pkg::KindW-1:0]  kind_r;
  logic [afbu_pkg::ByteW-1:0]  payload_r;
  logic [afbu_pkg::CountW-1:0] length_r;
  logic                        load, is_payload;

  // refill the output beat whenever it is empty or being taken
  assign load          = q_not_empty && (!out_valid_r || !out_stall);
  assign q_pop         = load;
  assign is_payload    = (q_head.kind == afbu_pkg::KIND_PAYLOAD);
  assign out_valid_nxt = load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r    <= q_head.kind;
      payload_r <= is_payload ? q_head.data : '0;
      length_r  <= is_payload ? '0 : q_head.count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_payload_byte = payload_r;
  assign out_frame_length = length_r;

endmodule

// ===== hdl/async_frame_byte_unstuffer_core.sv =====
// Receive-side byte unstuffer for asynchronous framed links.
// Input channel: in_valid/in_stall carry one line byte (in_data_byte) and its
// line-error flag per beat. Output channel: out_valid/out_stall carry zero or
// one result per input beat: a decoded payload byte (kind 0), a frame accept
// (kind 1) or a frame discard (kind 2) with the stored byte count.
// Flagged bytes, escape prefixes and bytes of a poisoned or full frame give
// no result; every unflagged end byte gives exactly one.
// Throughput: one byte per cycle while in_stall is low. Each result is written
// into the queue at the edge that accepts its input beat, then loaded into the
// output register when it reaches the queue head and that register is free.
// A two-entry queue sits between the classifier and the output register, so
// a stall on the output side reaches in_stall only once the queue fills.
// Results are never dropped while stalled; the output beat holds.
// Reset (rst_n low, synchronous) empties the queue and output, clears the
// byte count, escape and error marks, and loads register defaults:
// frame_limit 512, end_byte 0x7E, escape_byte 0x7D, escape_xor 0x20.
// Registers are written over the APB port at byte addresses 0, 4, 8, 12 and
// should be changed only while the block is idle.
module async_frame_byte_unstuffer_core #(
  parameter int unsigned MAX_FRAME_BYTES = afbu_pkg::MAX_FRAME_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH     = afbu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [afbu_pkg::ByteW-1:0]    in_data_byte,
  input  logic                          in_line_error,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [afbu_pkg::KindW-1:0]    out_kind,
  output logic [afbu_pkg::ByteW-1:0]    out_payload_byte,
  output logic [afbu_pkg::CountW-1:0]   out_frame_length,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [afbu_pkg::AddrW-1:0]    paddr,
  input  logic [afbu_pkg::DataW-1:0]    pwdata,
  output logic [afbu_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  afbu_pkg::afbu_cfg_t   cfg_r;
  afbu_pkg::afbu_entry_t push_entry, q_head;
  logic                  push, q_full, q_not_empty, q_pop, wr_en;
  logic [1:0]            reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_limit <= afbu_pkg::FRAME_LIMIT_RST;
      cfg_r.end_byte    <= afbu_pkg::END_BYTE_RST;
      cfg_r.escape_byte <= afbu_pkg::ESCAPE_BYTE_RST;
      cfg_r.escape_xor  <= afbu_pkg::ESCAPE_XOR_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        afbu_pkg::REG_FRAME_LIMIT: cfg_r.frame_limit <= pwdata[afbu_pkg::CountW-1:0];
        afbu_pkg::REG_END_BYTE:    cfg_r.end_byte    <= pwdata[afbu_pkg::ByteW-1:0];
        afbu_pkg::REG_ESCAPE_BYTE: cfg_r.escape_byte <= pwdata[afbu_pkg::ByteW-1:0];
        afbu_pkg::REG_ESCAPE_XOR:  cfg_r.escape_xor  <= pwdata[afbu_pkg::ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      afbu_pkg::REG_FRAME_LIMIT: prdata[afbu_pkg::CountW-1:0] = cfg_r.frame_limit;
      afbu_pkg::REG_END_BYTE:    prdata[afbu_pkg::ByteW-1:0]  = cfg_r.end_byte;
      afbu_pkg::REG_ESCAPE_BYTE: prdata[afbu_pkg::ByteW-1:0]  = cfg_r.escape_byte;
      afbu_pkg::REG_ESCAPE_XOR:  prdata[afbu_pkg::ByteW-1:0]  = cfg_r.escape_xor;
      default: ;
    endcase
  end

  assign in_stall = q_full;

  afbu_front #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .q_full        (q_full),
    .in_data_byte  (in_data_byte),
    .in_line_error (in_line_error),
    .cfg           (cfg_r),
    .push          (push),
    .push_entry    (push_entry)
  );

  afbu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  afbu_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_frame_length (out_frame_length)
  );

endmodule

// ===== hdl/afbu_checker.sv =====
module afbu_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [afbu_pkg::KindW-1:0]    out_kind,
  input logic [afbu_pkg::ByteW-1:0]    out_payload_byte,
  input logic [afbu_pkg::CountW-1:0]   out_frame_length
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
      $stable(out_payload_byte) && $stable(out_frame_length))
    else $error("stalled result beat changed");

  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == afbu_pkg::KIND_PAYLOAD |-> out_frame_length == '0)
    else $error("payload beat carries a frame length");

  a_end_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != afbu_pkg::KIND_PAYLOAD |-> out_payload_byte == '0)
    else $error("frame end beat carries a payload byte");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind async_frame_byte_unstuffer_core afbu_checker u_afbu_checker (.*);

// ===== dv/async_frame_byte_unstuffer_core_tb.sv =====
module async_frame_byte_unstuffer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import afbu_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 6;

  typedef struct {
    logic [ByteW-1:0] data;
    logic             bad;
  } line_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ByteW-1:0]  in_data_byte = '0;
  logic              in_line_error = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [KindW-1:0]  out_kind;
  logic [ByteW-1:0]  out_payload_byte;
  logic [CountW-1:0] out_frame_length;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  // decoder copy of the block's registers and frame state
  logic [CountW-1:0] lim_reg = FRAME_LIMIT_RST;
  logic [ByteW-1:0]  end_reg = END_BYTE_RST;
  logic [ByteW-1:0]  esc_reg = ESCAPE_BYTE_RST;
  logic [ByteW-1:0]  xor_reg = ESCAPE_XOR_RST;
  logic [CountW-1:0] stored_cnt = '0;
  logic              esc_armed = 1'b0;
  logic              frame_bad = 1'b0;

  line_beat_t  line_bytes_q[$];
  afbu_entry_t unstuffed_q[$];
  int          beats_queued = 0;
  int          fail_count = 0;
  int          dead_cycles = 0;
  logic        steady_mode = 1'b0;

  async_frame_byte_unstuffer_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_line_error    (in_line_error),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_frame_length (out_frame_length),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic unstuff_beat(input logic [ByteW-1:0] raw, input logic bad);
    logic [ByteW-1:0]  b;
    logic [CountW-1:0] lim;
    afbu_entry_t       r;
    b = raw;
    if (bad) begin
      frame_bad = 1'b1;
      return;
    end
    if (b == end_reg) begin
      r.kind  = (!frame_bad && stored_cnt > MIN_ACCEPT_COUNT) ? KIND_ACCEPT : KIND_DISCARD;
      r.data  = '0;
      r.count = stored_cnt;
      unstuffed_q.push_back(r);
      frame_bad  = 1'b0;
      esc_armed  = 1'b0;
      stored_cnt = '0;
      return;
    end
    if (b == esc_reg) begin
      esc_armed = 1'b1;
      return;
    end
    if ((b == (esc_reg ^ xor_reg) || b == (end_reg ^ xor_reg)) && esc_armed) begin
      esc_armed = 1'b0;
      b = b ^ xor_reg;
    end
    if (frame_bad)
      return;
    lim = (lim_reg > MAX_FRAME_BYTES_DEF) ? CountW'(MAX_FRAME_BYTES_DEF) : lim_reg;
    if (stored_cnt < lim) begin
      stored_cnt = stored_cnt + 1'b1;
      r.kind  = KIND_PAYLOAD;
      r.data  = b;
      r.count = '0;
      unstuffed_q.push_back(r);
    end else begin
      frame_bad = 1'b1;
    end
  endtask

  // driver: advance to the next queued beat once the current one is taken
  always @(posedge clk) begin : line_driver
    line_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        unstuff_beat(in_data_byte, in_line_error);
      if (!in_valid || !in_stall) begin
        if (line_bytes_q.size() != 0 && (steady_mode || $urandom_range(99) >= 6)) begin
          nxt = line_bytes_q.pop_front();
          in_valid      <= 1'b1;
          in_data_byte  <= nxt.data;
          in_line_error <= nxt.bad;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    afbu_entry_t want;
    out_stall <= !steady_mode && ($urandom_range(99) < 6);
    if (rst_n && out_valid && !out_stall) begin
      if (unstuffed_q.size() == 0) begin
        $error("unexpected result beat: kind %0d byte 0x%02h length %0d",
               out_kind, out_payload_byte, out_frame_length);
        fail_count++;
      end else begin
        want = unstuffed_q.pop_front();
        if (out_kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_kind);
          fail_count++;
        end
        if (out_payload_byte !== want.data) begin
          $error("payload_byte: expected 0x%02h, actual 0x%02h", want.data, out_payload_byte);
          fail_count++;
        end
        if (out_frame_length !== want.count) begin
          $error("frame_length: expected %0d, actual %0d", want.count, out_frame_length);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      dead_cycles <= 0;
    else
      dead_cycles <= dead_cycles + 1;
  end

  initial begin : watchdog
    while (dead_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  task automatic put_beat(input logic [ByteW-1:0] data, input logic bad);
    line_beat_t t;
    t.data = data;
    t.bad  = bad;
    line_bytes_q.push_back(t);
    beats_queued++;
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [DataW-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FRAME_LIMIT: lim_reg = val[CountW-1:0];
      REG_END_BYTE:    end_reg = val[ByteW-1:0];
      REG_ESCAPE_BYTE: esc_reg = val[ByteW-1:0];
      REG_ESCAPE_XOR:  xor_reg = val[ByteW-1:0];
      default: ;
    endcase
  endtask

  // hold the sender until every predicted beat is out, then let the pipe settle
  task automatic wait_idle();
    while (line_bytes_q.size() != 0 || in_valid || unstuffed_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed frames with stuffed content, the rest line noise
  task automatic queue_traffic(input int n_beats);
    int               start;
    int               len;
    int               k;
    logic [ByteW-1:0] b;
    start = beats_queued;
    while (beats_queued - start < n_beats) begin
      if ($urandom_range(99) < 80) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
        for (int i = 0; i < len; i++) begin
          k = $urandom_range(99);
          if (k < 3) begin
            put_beat(ByteW'($urandom), 1'b1);
          end else if (k < 6) begin
            put_beat(esc_reg, 1'b0);
          end else begin
            if (k < 20)
              b = $urandom_range(1) ? end_reg : esc_reg;
            else
              b = ByteW'($urandom);
            if (b == end_reg || b == esc_reg) begin
              put_beat(esc_reg, 1'b0);
              put_beat(b ^ xor_reg, 1'b0);
            end else begin
              put_beat(b, 1'b0);
            end
          end
        end
        put_beat(end_reg, 1'b0);
      end else begin
        put_beat(ByteW'($urandom), $urandom_range(7) == 0);
      end
    end
  endtask

  task automatic run_phase(input logic [CountW-1:0] lim, input logic [ByteW-1:0] eb,
                           input logic [ByteW-1:0] esc, input logic [ByteW-1:0] xm,
                           input int n_beats, input logic steady);
    reg_write(REG_FRAME_LIMIT, DataW'(lim));
    reg_write(REG_END_BYTE, DataW'(eb));
    reg_write(REG_ESCAPE_BYTE, DataW'(esc));
    reg_write(REG_ESCAPE_XOR, DataW'(xm));
    steady_mode = steady;
    queue_traffic(n_beats);
    wait_idle();
    steady_mode = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values: empty and back-to-back end bytes
    put_beat(8'h7E, 1'b0);
    put_beat(8'h7E, 1'b0);
    // three bytes accept, two bytes discard
    put_beat(8'h00, 1'b0);
    put_beat(8'hFF, 1'b0);
    put_beat(8'h41, 1'b0);
    put_beat(8'h7E, 1'b0);
    put_beat(8'h11, 1'b0);
    put_beat(8'h22, 1'b0);
    put_beat(8'h7E, 1'b0);
    // both escaped codes, a plain byte leaving the mark armed
    put_beat(8'h7D, 1'b0);
    put_beat(8'h5E, 1'b0);
    put_beat(8'h7D, 1'b0);
    put_beat(8'h5D, 1'b0);
    put_beat(8'h7D, 1'b0);
    put_beat(8'h41, 1'b0);
    put_beat(8'h5E, 1'b0);
    put_beat(8'h7E, 1'b0);
    // flagged byte poisons the frame, later bytes drop
    put_beat(8'hFF, 1'b1);
    put_beat(8'h01, 1'b0);
    put_beat(8'h7E, 1'b0);
    // end byte clears an armed escape, unarmed code passes as is
    put_beat(8'h7D, 1'b0);
    put_beat(8'h7E, 1'b0);
    put_beat(8'h5E, 1'b0);
    put_beat(8'h7E, 1'b0);
    queue_traffic(250);
    wait_idle();

    run_phase(13'd3, 8'h7E, 8'h7D, 8'h20, 200, 1'b0);
    run_phase(13'd0, 8'h7E, 8'h7D, 8'h20, 60, 1'b0);
    run_phase(13'd1, 8'h00, 8'hFF, 8'hFF, 150, 1'b0);
    run_phase(13'd4096, 8'hFF, 8'h00, 8'h00, 200, 1'b0);
    run_phase(13'd8191, 8'h7E, 8'h7E, 8'h20, 120, 1'b0);
    run_phase(CountW'($urandom_range(1, 40)), ByteW'($urandom), ByteW'($urandom),
              ByteW'($urandom), 300, 1'b1);
    run_phase(FRAME_LIMIT_RST, END_BYTE_RST, ESCAPE_BYTE_RST, ESCAPE_XOR_RST, 120, 1'b0);

    if (unstuffed_q.size() != 0) begin
      $error("%0d predicted results never arrived", unstuffed_q.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/afbu_pkg.sv
hdl/afbu_front.sv
hdl/afbu_queue.sv
hdl/afbu_back.sv
hdl/async_frame_byte_unstuffer_core.sv
hdl/afbu_checker.sv
dv/async_frame_byte_unstuffer_core_tb.sv
